// ===== sv/apf_pkg.sv =====
// Shared types and constants for the articulation point finder.
// No dependencies; imported by every module of the block.
package apf_pkg;

    localparam int NUM_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int VTX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int ARC_DEPTH    = 512;
    localparam int ARC_AW       = 9;
    localparam int ARC_PTR_W    = 10;
    localparam int ARC_CAP      = ((2 * MAX_EDGES) < ARC_DEPTH) ? (2 * MAX_EDGES) : ARC_DEPTH;
    localparam int STACK_DEPTH  = 64;
    localparam int STACK_AW     = 6;

    localparam logic [ARC_PTR_W-1:0] ARC_NIL   = 10'h3FF;
    localparam logic [CNT_W-1:0]     NO_PARENT = 7'd64;
    localparam logic [CNT_W-1:0]     VERTEX_COUNT_RESET = 7'd64;
    localparam logic [CNT_W-1:0]     NUM_VTX_C = 7'(NUM_VERTICES);
    localparam logic [CNT_W-1:0]     STACK_FULL = 7'(STACK_DEPTH);

    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;

    typedef struct packed {
        logic             func;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } in_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             found;
        logic             last;
        logic             dropped;
    } out_t;

    // per-vertex search record
    typedef struct packed {
        logic [CNT_W-1:0] disc;
        logic [CNT_W-1:0] low;
        logic [CNT_W-1:0] parent;
        logic [CNT_W-1:0] child;
        logic             cut;
    } rec_t;

    localparam rec_t CLEAR_REC = '{disc: '0, low: '0, parent: NO_PARENT, child: '0, cut: 1'b0};

    typedef struct packed {
        logic [VTX_W-1:0]     v;
        logic [ARC_PTR_W-1:0] a;
    } frame_t;

    typedef struct packed {
        logic [VTX_W-1:0]  head_addr;
        logic [ARC_AW-1:0] arc_addr;
    } rd_req_t;

    typedef struct packed {
        logic [ARC_PTR_W-1:0] head;
        logic [VTX_W-1:0]     target;
        logic [ARC_PTR_W-1:0] next;
    } rd_rsp_t;

endpackage

// ===== sv/apf_arc_store.sv =====
// Adjacency store: arc memory, per-vertex list heads with valid bits, edge loader.
// Depends on apf_pkg.
module apf_arc_store
    import apf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [VTX_W-1:0] vertex_a,
    input  logic [VTX_W-1:0] vertex_b,
    input  logic [CNT_W-1:0] active_n,
    input  rd_req_t          rd_req,
    output rd_rsp_t          rd_rsp,
    output logic             busy,
    output logic             drop_flag
);

    typedef enum logic [2:0] {
        L_IDLE   = 3'b001,
        L_FIRST  = 3'b010,
        L_SECOND = 3'b100
    } ld_state_t;

    ld_state_t ld_state_reg, ld_state_next;
    logic [VTX_W-1:0]     a_reg, b_reg;
    logic [ARC_PTR_W-1:0] cnt_reg, cnt_next;
    logic                 drop_reg, drop_next;
    logic [NUM_VERTICES-1:0] head_vld_reg;

    logic [ARC_PTR_W-1:0] head_mem [NUM_VERTICES];
    logic [VTX_W-1:0]     tgt_mem  [ARC_DEPTH];
    logic [ARC_PTR_W-1:0] nxt_mem  [ARC_DEPTH];

    logic [ARC_PTR_W-1:0] head_rd_reg, tgt_link;
    logic [VTX_W-1:0]     tgt_rd_reg;
    logic [ARC_PTR_W-1:0] nxt_rd_reg;
    logic [VTX_W-1:0]     head_raddr, head_waddr, arc_tgt;
    logic                 arc_we, bad;
    logic [ARC_PTR_W:0]   cnt_plus2;

    assign cnt_plus2 = {1'b0, cnt_reg} + 11'd2;
    assign bad = ({1'b0, vertex_a} >= active_n) || ({1'b0, vertex_b} >= active_n)
                 || (cnt_plus2 > 11'(ARC_CAP));

    always_comb
    begin
        ld_state_next = ld_state_reg;
        cnt_next      = cnt_reg;
        drop_next     = drop_reg;
        arc_we        = 1'b0;
        head_raddr    = rd_req.head_addr;
        head_waddr    = a_reg;
        arc_tgt       = b_reg;
        tgt_link      = head_rd_reg;
        case (ld_state_reg)
            L_IDLE:
            begin
                // search reads go through unless an edge transfer needs the head of a
                if (load)
                begin
                    head_raddr = vertex_a;
                    if (bad)
                        drop_next = 1'b1;
                    else
                        ld_state_next = L_FIRST;
                end
            end
            L_FIRST:
            begin
                head_raddr    = b_reg;
                arc_we        = 1'b1;
                cnt_next      = cnt_reg + 10'd1;
                ld_state_next = L_SECOND;
            end
            L_SECOND:
            begin
                arc_we     = 1'b1;
                head_waddr = b_reg;
                arc_tgt    = a_reg;
                // self loop: head of b was just rewritten
                if (a_reg == b_reg)
                    tgt_link = cnt_reg - 10'd1;
                cnt_next      = cnt_reg + 10'd1;
                ld_state_next = L_IDLE;
            end
            default:
                ld_state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_state_reg <= L_IDLE;
            cnt_reg      <= '0;
            drop_reg     <= 1'b0;
            head_vld_reg <= '0;
        end
        else
        begin
            ld_state_reg <= ld_state_next;
            cnt_reg      <= cnt_next;
            drop_reg     <= drop_next;
            if (arc_we)
                head_vld_reg[head_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_state_reg == L_IDLE && load)
        begin
            a_reg <= vertex_a;
            b_reg <= vertex_b;
        end
        if (arc_we)
        begin
            tgt_mem[cnt_reg[ARC_AW-1:0]] <= arc_tgt;
            nxt_mem[cnt_reg[ARC_AW-1:0]] <= tgt_link;
            head_mem[head_waddr]         <= cnt_reg;
        end
        head_rd_reg <= head_vld_reg[head_raddr] ? head_mem[head_raddr] : ARC_NIL;
        tgt_rd_reg  <= tgt_mem[rd_req.arc_addr];
        nxt_rd_reg  <= nxt_mem[rd_req.arc_addr];
    end

    assign rd_rsp    = '{head: head_rd_reg, target: tgt_rd_reg, next: nxt_rd_reg};
    assign busy      = (ld_state_reg != L_IDLE);
    assign drop_flag = drop_reg;

endmodule

// ===== sv/apf_dfs_core.sv =====
// Search sequencer: clears vertex records, walks the graph with an explicit
// stack, then scans the cut marks into the output register. Depends on apf_pkg.
module apf_dfs_core
    import apf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] active_n,
    input  logic             drop_flag,
    output rd_req_t          rd_req,
    input  rd_rsp_t          rd_rsp,
    output logic             busy,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_CLEAR     = 12'b000000000010,
        S_ROOT      = 12'b000000000100,
        S_ROOT_WAIT = 12'b000000001000,
        S_STEP      = 12'b000000010000,
        S_ARC_WAIT  = 12'b000000100000,
        S_VREC_WAIT = 12'b000001000000,
        S_POP_WAIT  = 12'b000010000000,
        S_POP_REC   = 12'b000100000000,
        S_SCAN      = 12'b001000000000,
        S_SCAN_WAIT = 12'b010000000000,
        S_FLUSH     = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next, visit_reg, visit_next, sp_reg, sp_next;
    logic [CNT_W-1:0]     lowc_reg, lowc_next;
    logic [VTX_W-1:0]     top_u_reg, top_u_next, v_reg, v_next, pend_reg, pend_next;
    logic [ARC_PTR_W-1:0] top_a_reg, top_a_next;
    rec_t                 urec_reg, urec_next;
    logic                 have_reg, have_next, out_valid_reg, out_valid_next;
    out_t                 out_reg, out_next;

    rec_t   rec_mem [NUM_VERTICES];
    frame_t stk_mem [STACK_DEPTH];
    rec_t   rec_rd_reg, rec_wdata, vr, wr;
    frame_t stk_rd_reg, stk_wdata;
    logic                rec_re, rec_we, stk_re, stk_we, slot_free;
    logic [VTX_W-1:0]    rec_raddr, rec_waddr;
    logic [STACK_AW-1:0] stk_raddr, stk_waddr;
    logic [CNT_W-1:0]    sp_dec;

    assign slot_free = !out_valid_reg || !out_stall;
    assign sp_dec    = sp_reg - 7'd1;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        visit_next     = visit_reg;
        sp_next        = sp_reg;
        lowc_next      = lowc_reg;
        top_u_next     = top_u_reg;
        top_a_next     = top_a_reg;
        v_next         = v_reg;
        pend_next      = pend_reg;
        urec_next      = urec_reg;
        have_next      = have_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        rec_re         = 1'b0;
        rec_raddr      = idx_reg[VTX_W-1:0];
        rec_we         = 1'b0;
        rec_waddr      = top_u_reg;
        rec_wdata      = urec_reg;
        stk_re         = 1'b0;
        stk_raddr      = sp_dec[STACK_AW-1:0] - 6'd1;
        stk_we         = 1'b0;
        stk_waddr      = sp_dec[STACK_AW-1:0];
        stk_wdata      = '{v: top_u_reg, a: top_a_reg};
        rd_req         = '{head_addr: idx_reg[VTX_W-1:0], arc_addr: top_a_reg[ARC_AW-1:0]};
        vr             = (v_reg == top_u_reg) ? urec_reg : rec_rd_reg;
        wr             = rec_rd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    have_next  = 1'b0;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                rec_we    = 1'b1;
                rec_waddr = idx_reg[VTX_W-1:0];
                rec_wdata = CLEAR_REC;
                idx_next  = idx_reg + 7'd1;
                if (idx_reg == NUM_VTX_C - 7'd1)
                begin
                    idx_next   = '0;
                    visit_next = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (idx_reg >= active_n)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    rec_re     = 1'b1;
                    state_next = S_ROOT_WAIT;
                end
            end
            S_ROOT_WAIT:
            begin
                if (rec_rd_reg.disc != '0)
                begin
                    idx_next   = idx_reg + 7'd1;
                    state_next = S_ROOT;
                end
                else
                begin
                    visit_next = visit_reg + 7'd1;
                    urec_next  = '{disc: visit_reg + 7'd1, low: visit_reg + 7'd1,
                                   parent: NO_PARENT, child: '0, cut: 1'b0};
                    top_u_next = idx_reg[VTX_W-1:0];
                    top_a_next = rd_rsp.head;
                    sp_next    = 7'd1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (top_a_reg[ARC_PTR_W-1])
                begin
                    // list exhausted: write back and pop
                    rec_we  = 1'b1;
                    sp_next = sp_dec;
                    if (sp_reg == 7'd1)
                    begin
                        idx_next   = idx_reg + 7'd1;
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        lowc_next  = urec_reg.low;
                        stk_re     = 1'b1;
                        state_next = S_POP_WAIT;
                    end
                end
                else
                    state_next = S_ARC_WAIT;
            end
            S_ARC_WAIT:
            begin
                top_a_next = rd_rsp.next;
                v_next     = rd_rsp.target;
                rd_req.head_addr = rd_rsp.target;
                if ({1'b0, rd_rsp.target} >= active_n)
                    state_next = S_STEP;
                else
                begin
                    rec_re     = 1'b1;
                    rec_raddr  = rd_rsp.target;
                    state_next = S_VREC_WAIT;
                end
            end
            S_VREC_WAIT:
            begin
                state_next = S_STEP;
                if (vr.disc == '0)
                begin
                    if (sp_reg < STACK_FULL)
                    begin
                        rec_we          = 1'b1;
                        rec_wdata.child = urec_reg.child + 7'd1;
                        stk_we          = 1'b1;
                        visit_next      = visit_reg + 7'd1;
                        urec_next  = '{disc: visit_reg + 7'd1, low: visit_reg + 7'd1,
                                       parent: {1'b0, top_u_reg}, child: '0, cut: 1'b0};
                        top_u_next = v_reg;
                        top_a_next = rd_rsp.head;
                        sp_next    = sp_reg + 7'd1;
                    end
                end
                else if ({1'b0, v_reg} != urec_reg.parent && vr.disc < urec_reg.low)
                    urec_next.low = vr.disc;
            end
            S_POP_WAIT:
            begin
                rec_re     = 1'b1;
                rec_raddr  = stk_rd_reg.v;
                state_next = S_POP_REC;
            end
            S_POP_REC:
            begin
                if (lowc_reg < wr.low)
                    wr.low = lowc_reg;
                if (wr.parent == NO_PARENT && wr.child > 7'd1)
                    wr.cut = 1'b1;
                if (wr.parent != NO_PARENT && lowc_reg >= wr.disc)
                    wr.cut = 1'b1;
                urec_next  = wr;
                top_u_next = stk_rd_reg.v;
                top_a_next = stk_rd_reg.a;
                state_next = S_STEP;
            end
            S_SCAN:
            begin
                if (idx_reg >= active_n)
                    state_next = S_FLUSH;
                else
                begin
                    rec_re     = 1'b1;
                    state_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                if (!rec_rd_reg.cut)
                begin
                    idx_next   = idx_reg + 7'd1;
                    state_next = S_SCAN;
                end
                else if (!have_reg)
                begin
                    pend_next  = idx_reg[VTX_W-1:0];
                    have_next  = 1'b1;
                    idx_next   = idx_reg + 7'd1;
                    state_next = S_SCAN;
                end
                else if (slot_free)
                begin
                    out_next       = '{vertex: pend_reg, found: 1'b1, last: 1'b0,
                                       dropped: drop_flag};
                    out_valid_next = 1'b1;
                    pend_next      = idx_reg[VTX_W-1:0];
                    idx_next       = idx_reg + 7'd1;
                    state_next     = S_SCAN;
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    out_next       = '{vertex: have_reg ? pend_reg : '0, found: have_reg,
                                       last: 1'b1, dropped: drop_flag};
                    out_valid_next = 1'b1;
                    have_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            visit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            have_reg      <= have_next;
            visit_reg     <= visit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        sp_reg    <= sp_next;
        lowc_reg  <= lowc_next;
        top_u_reg <= top_u_next;
        top_a_reg <= top_a_next;
        v_reg     <= v_next;
        pend_reg  <= pend_next;
        urec_reg  <= urec_next;
        out_reg   <= out_next;
        if (rec_we)
            rec_mem[rec_waddr] <= rec_wdata;
        if (rec_re)
            rec_rd_reg <= rec_mem[rec_raddr];
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rd_reg <= stk_mem[stk_raddr];
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/articulation_point_finder.sv =====
// Edge load: each edge item takes a head read and two arc writes; a dropped edge skips them.
// Run: clear the vertex records, then handle roots, arc visits and pops through
// the vertex record memory, then the report scan over the vertices.
// Results leave through one output register; the last one carries last = 1.
// Reset: asynchronous, active low; list heads empty, arc count and drop flag zero,
// vertex_count 64. The vertex record memory is swept clear at the start of each run.
module articulation_point_finder
    import apf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    // results
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data
);

    logic [CNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0] active_n;
    logic             store_busy, core_busy, drop_flag, in_xfer;
    rd_req_t          rd_req;
    rd_rsp_t          rd_rsp;

    // register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= VERTEX_COUNT_RESET;
        else if (psel && penable && pwrite && paddr == REG_VERTEX_COUNT)
            vertex_count_reg <= pwdata[CNT_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_VERTEX_COUNT) ? {25'd0, vertex_count_reg} : 32'd0;

    // active count is capped at the vertex capacity
    assign active_n = (vertex_count_reg < NUM_VTX_C) ? vertex_count_reg : NUM_VTX_C;

    // one item at a time: hold off while loading an edge or searching
    assign in_stall = store_busy || core_busy;
    assign in_xfer  = in_valid && !in_stall;

    apf_arc_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_xfer && in_data.func == FUNC_EDGE),
        .vertex_a  (in_data.vertex_a),
        .vertex_b  (in_data.vertex_b),
        .active_n  (active_n),
        .rd_req    (rd_req),
        .rd_rsp    (rd_rsp),
        .busy      (store_busy),
        .drop_flag (drop_flag)
    );

    apf_dfs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_xfer && in_data.func == FUNC_RUN),
        .active_n  (active_n),
        .drop_flag (drop_flag),
        .rd_req    (rd_req),
        .rd_rsp    (rd_rsp),
        .busy      (core_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
